// ===== hdl/fsta_pkg.sv =====
// Shared types and constants for the floor span texture address block.
package fsta_pkg;
	localparam int TexLog2 = 6;
	localparam int FracBits = 16;
	localparam int GainFrac = 30;
	localparam int RowW = 12;
	localparam int IdxW = 12;
	localparam int CfgIdxW = 3;
	localparam int QDepth = 2;

	localparam logic [31:0] TexMask = (32'd1 << TexLog2) - 32'd1;

	localparam logic [CfgIdxW-1:0] REG_ORIGIN_U = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_V = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_HORIZON = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DEPTH = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LEFT_U = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LEFT_V = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_GAIN_U = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_GAIN_V = 3'd7;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_ROW   = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_t;

	// classified transaction passed from front to back
	typedef struct packed {
		cmd_t             cmd;
		logic [RowW-1:0]  row_dist;
	} task_t;
endpackage

// ===== hdl/fsta_front.sv =====
// Front end: accepts transactions, classifies against the horizon, queues them.
module fsta_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         action,
	input  logic [fsta_pkg::RowW-1:0]    row_index,
	input  logic [fsta_pkg::RowW-1:0]    horizon_row,
	output logic                         q_valid,
	output fsta_pkg::task_t              q_task,
	input  logic                         q_take
);
	fsta_pkg::task_t entry_q [fsta_pkg::QDepth];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	fsta_pkg::task_t t;
	logic acc;

	always_comb begin
		t.row_dist = row_index - horizon_row;
		if (action) t.cmd = fsta_pkg::CMD_PIXEL;
		else if (row_index <= horizon_row) t.cmd = fsta_pkg::CMD_ERROR;
		else t.cmd = fsta_pkg::CMD_ROW;
	end

	assign full = (count_q == 2'(fsta_pkg::QDepth));
	assign acc = push && !full;
	assign q_valid = (count_q != 2'd0);
	assign q_task = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (acc) entry_q[wr_ptr_q] <= t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (acc) wr_ptr_q <= !wr_ptr_q;
			if (q_take) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, acc} - {1'b0, q_take};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count overflow");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("take from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_take) |=> full) else $error("full dropped without take");
`endif
endmodule

// ===== hdl/fsta_div.sv =====
// Radix-2 restoring divider: 32-bit signed numerator by 12-bit positive divisor.
module fsta_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               numer,
	input  logic [fsta_pkg::RowW-1:0] denom,
	output logic                      done,
	output logic [31:0]               quot
);
	logic [31:0] q_q;
	logic [fsta_pkg::RowW:0] rem_q;
	logic [fsta_pkg::RowW-1:0] den_q;
	logic neg_q, busy_q;
	logic [4:0] cnt_q;
	logic [fsta_pkg::RowW:0] trial;
	logic [fsta_pkg::RowW+1:0] diff;

	assign trial = {rem_q[fsta_pkg::RowW-1:0], q_q[31]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= numer[31];
			q_q <= numer[31] ? (32'd0 - numer) : numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (!diff[fsta_pkg::RowW+1]) begin
				rem_q <= diff[fsta_pkg::RowW:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? (32'd0 - q_q) : q_q;
endmodule

// ===== hdl/fsta_back.sv =====
// Back end: row setup (divide, four scaled products) and per-pixel stepping.
module fsta_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  fsta_pkg::task_t               q_task,
	output logic                          q_take,
	input  logic [15:0]                   origin_u,
	input  logic [15:0]                   origin_v,
	input  logic [31:0]                   depth_numerator,
	input  logic [31:0]                   left_dir_u,
	input  logic [31:0]                   left_dir_v,
	input  logic [31:0]                   span_gain_u,
	input  logic [31:0]                   span_gain_v,
	output logic                          empty,
	input  logic                          pop,
	output logic [fsta_pkg::IdxW-1:0]     texel_index,
	output logic                          row_error
);
	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_BASE = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] cur_u_q, cur_v_q, step_u_q, step_v_q, dist_q;
	logic [1:0] mul_sel_q;
	logic out_valid_q;
	logic div_start, div_done;
	logic [31:0] quot;
	logic [31:0] gain;
	logic signed [63:0] prod;
	logic [31:0] scaled_val;
	logic out_free, issue, load_out;
	logic [fsta_pkg::IdxW-1:0] tex_cur;
	logic [31:0] nxt_u, nxt_v;

	fsta_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(depth_numerator),
		.denom(q_task.row_dist), .done(div_done), .quot(quot)
	);

	always_comb begin
		case (mul_sel_q)
			2'd0: gain = left_dir_u;
			2'd1: gain = left_dir_v;
			2'd2: gain = span_gain_u;
			default: gain = span_gain_v;
		endcase
	end
	// arithmetic shift is floor division by 2^30
	assign prod = $signed(dist_q) * $signed(gain);
	assign scaled_val = 32'(prod >>> fsta_pkg::GainFrac);

	function automatic logic [fsta_pkg::IdxW-1:0] texel(input logic [31:0] u,
		input logic [31:0] v);
		logic [31:0] iu, iv, w;
		iu = (u >> fsta_pkg::FracBits) & fsta_pkg::TexMask;
		iv = (v >> fsta_pkg::FracBits) & fsta_pkg::TexMask;
		w = (iv << fsta_pkg::TexLog2) | iu;
		return w[fsta_pkg::IdxW-1:0];
	endfunction

	assign tex_cur = texel(cur_u_q, cur_v_q);
	assign out_free = !out_valid_q || pop;
	assign issue = (state_q == ST_RUN) && q_valid && out_free
		&& (q_task.cmd != fsta_pkg::CMD_ROW);
	assign div_start = (state_q == ST_RUN) && q_valid
		&& (q_task.cmd == fsta_pkg::CMD_ROW);
	assign load_out = issue || ((state_q == ST_BASE) && out_free);
	assign q_take = load_out;
	assign empty = !out_valid_q;
	assign nxt_u = cur_u_q + step_u_q;
	assign nxt_v = cur_v_q + step_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			out_valid_q <= 1'b0;
			mul_sel_q <= 2'd0;
			dist_q <= '0;
			cur_u_q <= '0;
			cur_v_q <= '0;
			step_u_q <= '0;
			step_v_q <= '0;
			texel_index <= '0;
			row_error <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				ST_RUN: begin
					if (div_start) state_q <= ST_DIV;
					else if (issue) begin
						if (q_task.cmd == fsta_pkg::CMD_ERROR) begin
							texel_index <= '0;
							row_error <= 1'b1;
						end else begin
							texel_index <= tex_cur;
							row_error <= 1'b0;
							cur_u_q <= nxt_u;
							cur_v_q <= nxt_v;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						dist_q <= quot;
						mul_sel_q <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_sel_q <= mul_sel_q + 2'd1;
					case (mul_sel_q)
						2'd0: cur_u_q <= scaled_val;
						2'd1: cur_v_q <= scaled_val;
						2'd2: step_u_q <= scaled_val;
						default: begin
							step_v_q <= scaled_val;
							state_q <= ST_BASE;
						end
					endcase
				end
				ST_BASE: begin
					if (out_free) begin
						cur_u_q <= nxt_u + {origin_u, 16'h0000};
						cur_v_q <= nxt_v + {origin_v, 16'h0000};
						texel_index <= texel(cur_u_q + {origin_u, 16'h0000},
							cur_v_q + {origin_v, 16'h0000});
						row_error <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_take_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> (state_q == ST_RUN || state_q == ST_BASE))
		else $error("take outside run or base");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> $stable(texel_index))
		else $error("waiting result changed");
`endif
endmodule

// ===== hdl/floor_span_texture_address_top.sv =====
// Top level: configuration registers, front classifier and back address engine.
// A next-pixel transaction goes through the two-entry queue into the output register;
// pixels can issue one per cycle while the output register is free and no row is being set up.
// A row start's result passes the divider start, the 32-step radix-2 divide, four
// multiplies on one 32x32 multiplier and the base load into the output register.
// arst_n clears registers, positions, steps, queue and output valid.
module floor_span_texture_address_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [11:0] row_index,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] texel_index,
	output logic        row_error,
	input  logic        cfg_we,
	input  logic [fsta_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic [15:0] origin_u_q, origin_v_q;
	logic [11:0] horizon_q;
	logic [31:0] depth_q, left_u_q, left_v_q, gain_u_q, gain_v_q;
	logic q_valid, q_take;
	fsta_pkg::task_t q_task;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_u_q <= '0; origin_v_q <= '0; horizon_q <= '0; depth_q <= '0;
			left_u_q <= '0; left_v_q <= '0; gain_u_q <= '0; gain_v_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fsta_pkg::REG_ORIGIN_U: origin_u_q <= cfg_data[15:0];
				fsta_pkg::REG_ORIGIN_V: origin_v_q <= cfg_data[15:0];
				fsta_pkg::REG_HORIZON:  horizon_q <= cfg_data[11:0];
				fsta_pkg::REG_DEPTH:    depth_q <= cfg_data;
				fsta_pkg::REG_LEFT_U:   left_u_q <= cfg_data;
				fsta_pkg::REG_LEFT_V:   left_v_q <= cfg_data;
				fsta_pkg::REG_GAIN_U:   gain_u_q <= cfg_data;
				fsta_pkg::REG_GAIN_V:   gain_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fsta_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.row_index(row_index), .horizon_row(horizon_q), .q_valid(q_valid),
		.q_task(q_task), .q_take(q_take)
	);

	fsta_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_task(q_task),
		.q_take(q_take), .origin_u(origin_u_q), .origin_v(origin_v_q),
		.depth_numerator(depth_q), .left_dir_u(left_u_q), .left_dir_v(left_v_q),
		.span_gain_u(gain_u_q), .span_gain_v(gain_v_q), .empty(empty), .pop(pop),
		.texel_index(texel_index), .row_error(row_error)
	);
endmodule

// ===== tb/tb.sv =====
// Testbench for the floor span texture address block: table-driven and random stimulus.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        action = 1'b0;
	logic [11:0] row_index = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [11:0] texel_index;
	logic        row_error;
	logic        cfg_we = 1'b0;
	logic [fsta_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	floor_span_texture_address_top dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	typedef struct {
		logic [11:0] texel;
		logic        err;
	} texel_t;

	texel_t texel_q[$];
	int     errors = 0;
	int     idle_cycles = 0;
	int     hold_left = 0;
	bit     stim_done = 1'b0;

	// predictor copy of registers and state
	logic signed [15:0] p_org_u, p_org_v;
	logic [11:0]        p_horizon;
	logic signed [31:0] p_depth, p_left_u, p_left_v, p_gain_u, p_gain_v;
	logic [31:0]        p_cur_u, p_cur_v, p_step_u, p_step_v;

	function automatic logic [31:0] scale_gain(longint row_dist, logic signed [31:0] gain);
		longint prod;
		prod = row_dist * longint'(gain);
		return 32'(prod >>> fsta_pkg::GainFrac);
	endfunction

	function automatic logic [11:0] texel_at(logic [31:0] u, logic [31:0] v);
		logic [5:0] iu, iv;
		iu = u[fsta_pkg::FracBits +: fsta_pkg::TexLog2];
		iv = v[fsta_pkg::FracBits +: fsta_pkg::TexLog2];
		return {iv, iu};
	endfunction

	function automatic texel_t predict_texel(logic act, logic [11:0] row);
		texel_t r;
		longint row_dist;
		r.err = 1'b0;
		if (act == 1'b0) begin
			if (row <= p_horizon) begin
				r.texel = '0;
				r.err = 1'b1;
				return r;
			end
			row_dist = longint'(p_depth) / longint'(int'(row) - int'(p_horizon));
			p_cur_u = (32'(int'(p_org_u)) << fsta_pkg::FracBits)
				+ scale_gain(row_dist, p_left_u);
			p_cur_v = (32'(int'(p_org_v)) << fsta_pkg::FracBits)
				+ scale_gain(row_dist, p_left_v);
			p_step_u = scale_gain(row_dist, p_gain_u);
			p_step_v = scale_gain(row_dist, p_gain_v);
		end
		r.texel = texel_at(p_cur_u, p_cur_v);
		p_cur_u = p_cur_u + p_step_u;
		p_cur_v = p_cur_v + p_step_v;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// write enable is dropped by the next send
	task automatic write_reg(logic [fsta_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			fsta_pkg::REG_ORIGIN_U: p_org_u = val[15:0];
			fsta_pkg::REG_ORIGIN_V: p_org_v = val[15:0];
			fsta_pkg::REG_HORIZON:  p_horizon = val[11:0];
			fsta_pkg::REG_DEPTH:    p_depth = val;
			fsta_pkg::REG_LEFT_U:   p_left_u = val;
			fsta_pkg::REG_LEFT_V:   p_left_v = val;
			fsta_pkg::REG_GAIN_U:   p_gain_u = val;
			fsta_pkg::REG_GAIN_V:   p_gain_v = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (texel_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// push stays high until a gap or a drain lowers it
	task automatic send(logic act, logic [11:0] row);
		cfg_we <= 1'b0;
		push <= 1'b1;
		action <= act;
		row_index <= row;
		@(posedge clk);
		while (full) @(posedge clk);
		texel_q.push_back(predict_texel(act, row));
	endtask

	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_regs(bit extreme);
		logic [31:0] v;
		for (int i = 0; i < 8; i++) begin
			v = $urandom();
			if (extreme) v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			if (i == int'(fsta_pkg::REG_HORIZON))
				v = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
			write_reg(fsta_pkg::CfgIdxW'(i), v);
		end
	endtask

	// directed rows: action, row, check_fixed, texel, err
	typedef struct {
		logic        act;
		logic [11:0] row;
		bit          fixed;
		logic [11:0] texel;
		logic        err;
	} dir_row_t;

	dir_row_t dir_tab[] = '{
		'{1'b1, 12'd0,    1'b1, 12'd0, 1'b0},
		'{1'b0, 12'd0,    1'b1, 12'd0, 1'b1},
		'{1'b0, 12'd4095, 1'b0, 12'd0, 1'b0},
		'{1'b1, 12'd4095, 1'b0, 12'd0, 1'b0},
		'{1'b1, 12'd0,    1'b0, 12'd0, 1'b0},
		'{1'b0, 12'd100,  1'b1, 12'd0, 1'b1},
		'{1'b0, 12'd99,   1'b1, 12'd0, 1'b1},
		'{1'b0, 12'd101,  1'b0, 12'd0, 1'b0},
		'{1'b1, 12'hfff,  1'b0, 12'd0, 1'b0},
		'{1'b1, 12'h555,  1'b0, 12'd0, 1'b0},
		'{1'b0, 12'd4095, 1'b0, 12'd0, 1'b0},
		'{1'b1, 12'haaa,  1'b0, 12'd0, 1'b0}
	};

	// result side
	initial begin
		texel_t want;
		int gap;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (texel_q.size() == 0) begin
					report_mismatch("unexpected result", texel_index, 0);
				end else begin
					want = texel_q.pop_front();
					if (texel_index !== want.texel) report_mismatch("texel_index", texel_index, want.texel);
					if (row_error !== want.err) report_mismatch("row_error", row_error, want.err);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
			end
		end
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || texel_q.size() == 0) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WatchLimit) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		{p_org_u, p_org_v, p_horizon, p_depth} = '0;
		{p_left_u, p_left_v, p_gain_u, p_gain_v} = '0;
		{p_cur_u, p_cur_v, p_step_u, p_step_v} = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_tab.size(); i++) begin
			if (i == 2) begin
				wait_drained();
				write_reg(fsta_pkg::REG_ORIGIN_U, 32'h0000_8000);
				write_reg(fsta_pkg::REG_ORIGIN_V, 32'h0000_7fff);
				write_reg(fsta_pkg::REG_HORIZON, 32'd0);
				write_reg(fsta_pkg::REG_DEPTH, 32'h7fff_ffff);
				write_reg(fsta_pkg::REG_LEFT_U, 32'h8000_0000);
				write_reg(fsta_pkg::REG_LEFT_V, 32'h7fff_ffff);
				write_reg(fsta_pkg::REG_GAIN_U, 32'h4000_0000);
				write_reg(fsta_pkg::REG_GAIN_V, 32'hc000_0000);
			end
			if (i == 5) begin
				wait_drained();
				write_reg(fsta_pkg::REG_HORIZON, 32'd100);
				write_reg(fsta_pkg::REG_DEPTH, 32'h8000_0000);
			end
			if (dir_tab[i].fixed) begin
				send(dir_tab[i].act, dir_tab[i].row);
				texel_q[$].texel = dir_tab[i].texel;
				texel_q[$].err = dir_tab[i].err;
			end else begin
				send(dir_tab[i].act, dir_tab[i].row);
			end
			random_gap();
		end
		wait_drained();
		write_reg(fsta_pkg::REG_HORIZON, 32'd4095);
		send(1'b0, 12'd4095);
		wait_drained();

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			random_regs(phase == 2);
			for (int n = 0; n < 80; n++) begin
				// receiver stalls on its own while items keep coming
				if (phase == 1 && n == 10) hold_left = 80;
				if ($urandom_range(0, 5) == 0)
					send(1'b0, $urandom_range(0, 1) ? 12'($urandom()) : 12'(p_horizon + $urandom_range(1, 40)));
				else if ($urandom_range(0, 19) == 0)
					send(1'b0, 12'($urandom_range(0, p_horizon)));
				else
					send(1'b1, 12'($urandom()));
				if (!(phase == 1 && n >= 10 && n < 30)) random_gap();
			end
		end
		wait_drained();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
